// ----- rtl/core/stride_prefetch_table_top_defines.svh -----
// Assertion macros for the stride prefetch table.
// Used by stride_prefetch_table_top; expects clk and rst_n in scope.
`ifndef STRIDE_PREFETCH_TABLE_TOP_DEFINES_SVH
`define STRIDE_PREFETCH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/spt_pkg.sv -----
// Shared types and constants of the stride prefetch table.
// No dependencies.
`default_nettype none
package spt_pkg;

  localparam int AGE_W_MAX = 8;

  typedef struct packed {
    logic        is_data_access;
    logic        is_miss;
    logic [63:0] address;
    logic [63:0] instr_pointer;
  } in_item_t;

  typedef struct packed {
    logic [63:0] prefetch_address;
    logic [1:0]  outcome;
  } out_item_t;

  // Outcome codes
  localparam logic [1:0] OUT_ISSUED    = 2'd0;
  localparam logic [1:0] OUT_NO_STRIDE = 2'd1;
  localparam logic [1:0] OUT_PAGE      = 2'd2;
  localparam logic [1:0] OUT_DUP       = 2'd3;

  // Mode codes
  localparam logic [1:0] MODE_REGION  = 2'd0;
  localparam logic [1:0] MODE_IP_ONLY = 2'd1;
  localparam logic [1:0] MODE_IP_NEXT = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_TSHIFT = 3'd1;
  localparam logic [2:0] REG_LOB    = 3'd2;
  localparam logic [2:0] REG_REACH  = 3'd3;
  localparam logic [2:0] REG_DR     = 3'd4;
  localparam logic [2:0] REG_POB    = 3'd5;
  localparam logic [2:0] REG_CROSS  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_MOD, ST_MUL, ST_ADD, ST_CHK
  } state_t;

  // Broadcast from the table row to every cell
  typedef struct packed {
    logic                 en;
    logic                 mode1;
    logic [63:0]          key;
    logic [63:0]          addr;
    logic                 hit_any;
    logic [AGE_W_MAX-1:0] hit_age;
    logic                 full;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/spt_cell.sv -----
// One table entry: key, last address, strides, LRU age.
// Depends on spt_pkg.
`default_nettype none
module spt_cell #(
  parameter int N  = 64,
  parameter int AW = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  spt_pkg::cell_ctl_t    ctl,
  input  wire                   prev_valid,
  output logic                  valid,
  output logic                  hit,
  output logic [AW-1:0]         age,
  output logic [31:0]           stride_sel
);

  logic          valid_r, valid_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic [63:0]   key_r, key_nxt, prev_r, prev_nxt;
  logic [31:0]   str_r, str_nxt, pstr_r, pstr_nxt, d, init_str;
  logic          conf_r, conf_nxt, ins;

  assign valid = valid_r;
  assign age   = age_r;
  assign hit   = valid_r && (key_r == ctl.key);
  assign d     = ctl.addr[31:0] - prev_r[31:0];
  assign init_str = ctl.mode1 ? 32'hFFFF_FFFF : 32'h0;
  // Insert into the first free cell, or the LRU cell when full
  assign ins = !ctl.hit_any &&
               (ctl.full ? (age_r == AW'(N - 1)) : (!valid_r && prev_valid));

  // Entry update
  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    key_nxt   = key_r;
    prev_nxt  = prev_r;
    str_nxt   = str_r;
    pstr_nxt  = pstr_r;
    conf_nxt  = conf_r;
    if (ctl.en) begin
      if (hit) begin
        if (!conf_r) begin
          if (pstr_r == d) begin
            str_nxt  = d;
            conf_nxt = 1'b1;
          end
        end else if (pstr_r != d) begin
          str_nxt  = init_str;
          conf_nxt = 1'b0;
        end
        pstr_nxt = d;
        prev_nxt = ctl.addr;
        age_nxt  = '0;
      end else if (ins) begin
        valid_nxt = 1'b1;
        key_nxt   = ctl.key;
        prev_nxt  = ctl.addr;
        str_nxt   = init_str;
        pstr_nxt  = '0;
        conf_nxt  = 1'b0;
        age_nxt   = '0;
      end else if (valid_r) begin
        if (!ctl.hit_any || (spt_pkg::AGE_W_MAX'(age_r) < ctl.hit_age)) begin
          age_nxt = age_r + AW'(1);
        end
      end
    end
  end

  assign stride_sel = hit ? str_nxt : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
    key_r  <= key_nxt;
    prev_r <= prev_nxt;
    str_r  <= str_nxt;
    pstr_r <= pstr_nxt;
    conf_r <= conf_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/spt_table.sv -----
// Row of table cells with hit, age and stride reductions.
// Depends on spt_pkg and spt_cell.
`default_nettype none
module spt_table #(
  parameter int N = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          en,
  input  wire          mode1,
  input  wire [63:0]   key,
  input  wire [63:0]   addr,
  output logic [31:0]  stride,
  output logic [N-1:0] hit_vec
);
  localparam int AW = $clog2(N);

  spt_pkg::cell_ctl_t ctl;
  logic [N-1:0]  vld;
  logic [AW-1:0] ages [N];
  logic [31:0]   strs [N];
  logic [spt_pkg::AGE_W_MAX-1:0] hage;
  logic [31:0]   sor;

  // Reductions over the row
  always_comb begin
    hage = '0;
    sor  = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_vec[i]) hage = hage | spt_pkg::AGE_W_MAX'(ages[i]);
      sor = sor | strs[i];
    end
  end

  assign ctl.en      = en;
  assign ctl.mode1   = mode1;
  assign ctl.key     = key;
  assign ctl.addr    = addr;
  assign ctl.hit_any = |hit_vec;
  assign ctl.hit_age = hage;
  assign ctl.full    = vld[N-1];
  assign stride = ctl.hit_any ? sor : (mode1 ? 32'hFFFF_FFFF : 32'h0);

  for (genvar g = 0; g < N; g++) begin : g_cell
    spt_cell #(.N(N), .AW(AW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid ((g == 0) ? 1'b1 : vld[(g == 0) ? 0 : g - 1]),
      .valid      (vld[g]),
      .hit        (hit_vec[g]),
      .age        (ages[g]),
      .stride_sel (strs[g])
    );
  end

endmodule
`default_nettype wire

// ----- rtl/core/stride_prefetch_table_top.sv -----
// Stride prefetch table top: control, config registers, history FIFO.
// Depends on spt_pkg, spt_table, stride_prefetch_table_top_defines.svh.
//
// Channel  Handshake             Payload
// in       start / busy          in_item (spt_pkg::in_item_t)
// out      out_strobe (1 cycle)  out_item (spt_pkg::out_item_t)
// cfg      APB psel/penable      paddr, pwdata, prdata
//
// A counted miss runs the table lookup and a serial modulo of the miss counter;
// it ends there when no prefetch address is formed (no result, or a no-stride
// result). The serial modulo needs extra subtractions after the prefetch
// interval is lowered below the counter. Ignored beats give no result.
// The table row updates in the lookup step; multiply, add and history compare
// follow as separate steps. Synchronous active-low reset; no clearing pass.
// Results cannot be stalled.
`default_nettype none
`include "stride_prefetch_table_top_defines.svh"
module stride_prefetch_table_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int HISTORY_DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  spt_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output spt_pkg::out_item_t out_item,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [4:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  // Config registers
  logic [1:0] mode_r;
  logic [5:0] tsh_r;
  logic [3:0] lob_r;
  logic [4:0] reach_r;
  logic [7:0] dr_r;
  logic [4:0] pob_r;
  logic       cross_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= spt_pkg::MODE_IP_NEXT;
      tsh_r   <= 6'd16;
      lob_r   <= 4'd6;
      reach_r <= 5'd2;
      dr_r    <= 8'd4;
      pob_r   <= 5'd12;
      cross_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        spt_pkg::REG_MODE:   mode_r  <= pwdata[1:0];
        spt_pkg::REG_TSHIFT: tsh_r   <= pwdata[5:0];
        spt_pkg::REG_LOB:    lob_r   <= pwdata[3:0];
        spt_pkg::REG_REACH:  reach_r <= pwdata[4:0];
        spt_pkg::REG_DR:     dr_r    <= pwdata[7:0];
        spt_pkg::REG_POB:    pob_r   <= pwdata[4:0];
        spt_pkg::REG_CROSS:  cross_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[4:2])
      spt_pkg::REG_MODE:   prdata = 32'(mode_r);
      spt_pkg::REG_TSHIFT: prdata = 32'(tsh_r);
      spt_pkg::REG_LOB:    prdata = 32'(lob_r);
      spt_pkg::REG_REACH:  prdata = 32'(reach_r);
      spt_pkg::REG_DR:     prdata = 32'(dr_r);
      spt_pkg::REG_POB:    prdata = 32'(pob_r);
      spt_pkg::REG_CROSS:  prdata = 32'(cross_r);
      default:             prdata = 32'h0;
    endcase
  end

  // Control and datapath registers
  spt_pkg::state_t state_r, state_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [8:0]  ph_r, ph_nxt;
  logic [63:0] addr_r, addr_nxt, key_r, key_nxt, tgt_r, tgt_nxt;
  logic [31:0] str_r, str_nxt;
  logic signed [37:0] prod_r, prod_nxt;
  logic        pbad_r, pbad_nxt;
  logic        ostb_r, ostb_nxt;
  spt_pkg::out_item_t oitem_r, oitem_nxt;
  logic [63:0] hist_r [HISTORY_DEPTH];
  logic [HCW-1:0] hcnt_r, hcnt_nxt;
  logic [HW-1:0]  hhead_r, hhead_nxt;
  logic        hwr;
  logic [HW-1:0] hwidx;

  logic        tbl_en;
  logic [31:0] tbl_stride;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [7:0]  dr_eff;
  logic [31:0] str_eff;
  logic [63:0] lmask, tsum;
  logic        hdup, counted;

  assign busy       = (state_r != spt_pkg::ST_IDLE);
  assign out_strobe = ostb_r;
  assign out_item   = oitem_r;
  assign dr_eff     = (dr_r == 8'd0) ? 8'd1 : dr_r;
  assign counted    = in_item.is_data_access && in_item.is_miss &&
                      (mode_r != spt_pkg::MODE_UNUSED);
  assign str_eff    = (str_r == 32'h0) ? (32'h1 << lob_r) : str_r;
  assign lmask      = (64'h1 << lob_r) - 64'h1;
  assign tsum       = addr_r + {{26{prod_r[37]}}, prod_r};

  spt_table #(.N(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (tbl_en),
    .mode1   (mode_r == spt_pkg::MODE_IP_ONLY),
    .key     (key_r),
    .addr    (addr_r),
    .stride  (tbl_stride),
    .hit_vec (hit_vec)
  );

  // History duplicate search
  always_comb begin
    hdup = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((HCW'(i) < hcnt_r) && (hist_r[i] == tgt_r)) hdup = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ph_nxt    = ph_r;
    addr_nxt  = addr_r;
    key_nxt   = key_r;
    str_nxt   = str_r;
    prod_nxt  = prod_r;
    tgt_nxt   = tgt_r;
    pbad_nxt  = pbad_r;
    ostb_nxt  = 1'b0;
    oitem_nxt = oitem_r;
    hcnt_nxt  = hcnt_r;
    hhead_nxt = hhead_r;
    hwr       = 1'b0;
    hwidx     = (hcnt_r == HCW'(HISTORY_DEPTH)) ? hhead_r : HW'(hcnt_r);
    tbl_en    = 1'b0;
    unique case (state_r)
      spt_pkg::ST_IDLE: begin
        if (start && counted) begin
          addr_nxt  = in_item.address;
          key_nxt   = (mode_r == spt_pkg::MODE_REGION) ?
                      (in_item.address >> tsh_r) : in_item.instr_pointer;
          state_nxt = spt_pkg::ST_LOOK;
        end
      end
      spt_pkg::ST_LOOK: begin
        tbl_en    = 1'b1;
        str_nxt   = tbl_stride;
        ph_nxt    = {1'b0, phase_r} + 9'd1;
        state_nxt = spt_pkg::ST_MOD;
      end
      spt_pkg::ST_MOD: begin
        if (ph_r >= {1'b0, dr_eff}) begin
          ph_nxt = ph_r - {1'b0, dr_eff};
        end else begin
          phase_nxt = ph_r[7:0];
          if (ph_r != 9'd0) begin
            state_nxt = spt_pkg::ST_IDLE;
          end else if (str_r == 32'hFFFF_FFFF) begin
            ostb_nxt  = 1'b1;
            oitem_nxt.prefetch_address = 64'h0;
            oitem_nxt.outcome = spt_pkg::OUT_NO_STRIDE;
            state_nxt = spt_pkg::ST_IDLE;
          end else begin
            state_nxt = spt_pkg::ST_MUL;
          end
        end
      end
      spt_pkg::ST_MUL: begin
        prod_nxt  = 38'($signed(str_eff)) * 38'($signed({1'b0, reach_r}));
        state_nxt = spt_pkg::ST_ADD;
      end
      spt_pkg::ST_ADD: begin
        tgt_nxt   = tsum & ~lmask;
        pbad_nxt  = !cross_r && ((addr_r >> pob_r) != ((tsum & ~lmask) >> pob_r));
        state_nxt = spt_pkg::ST_CHK;
      end
      spt_pkg::ST_CHK: begin
        ostb_nxt  = 1'b1;
        oitem_nxt.prefetch_address = tgt_r;
        state_nxt = spt_pkg::ST_IDLE;
        if (pbad_r) begin
          oitem_nxt.outcome = spt_pkg::OUT_PAGE;
        end else if (hdup) begin
          oitem_nxt.outcome = spt_pkg::OUT_DUP;
        end else begin
          oitem_nxt.outcome = spt_pkg::OUT_ISSUED;
          hwr = 1'b1;
          if (hcnt_r == HCW'(HISTORY_DEPTH)) begin
            hhead_nxt = (hhead_r == HW'(HISTORY_DEPTH - 1)) ? '0 : hhead_r + HW'(1);
          end else begin
            hcnt_nxt = hcnt_r + HCW'(1);
          end
        end
      end
      default: state_nxt = spt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spt_pkg::ST_IDLE;
      phase_r <= '0;
      ostb_r  <= 1'b0;
      hcnt_r  <= '0;
      hhead_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ostb_r  <= ostb_nxt;
      hcnt_r  <= hcnt_nxt;
      hhead_r <= hhead_nxt;
    end
    ph_r    <= ph_nxt;
    addr_r  <= addr_nxt;
    key_r   <= key_nxt;
    str_r   <= str_nxt;
    prod_r  <= prod_nxt;
    tgt_r   <= tgt_nxt;
    pbad_r  <= pbad_nxt;
    oitem_r <= oitem_nxt;
  end

  // History storage
  always_ff @(posedge clk) begin
    if (hwr) hist_r[hwidx] <= tgt_r;
  end

  // Checks
  `SPT_ASSERT_NOW(a_hit_onehot, 1'b1, $onehot0(hit_vec), "multiple table hits")
  `SPT_ASSERT_NOW(a_out_idle, out_strobe, !busy, "result while busy")
  `SPT_ASSERT_NOW(a_hcnt_max, 1'b1, hcnt_r <= HCW'(HISTORY_DEPTH), "history overflow")
  `SPT_ASSERT_NEXT(a_look_once, state_r == spt_pkg::ST_LOOK, state_r == spt_pkg::ST_MOD, "lookup not single-cycle")

endmodule
`default_nettype wire
